// ===== rtl/core/nand_page_read_sequencer_top_defines.svh =====
// Assertion macros used by the NAND page read sequencer back end.
`ifndef NAND_PAGE_READ_SEQUENCER_TOP_DEFINES_SVH
`define NAND_PAGE_READ_SEQUENCER_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define NPRS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nprs: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define NPRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nprs: next-cycle check failed");

`endif

// ===== rtl/core/nprs_pkg.sv =====
// Types, codes and constants of the NAND page read sequencer.
package nprs_pkg;

    // Defaults of the top level parameters.
    localparam int unsigned ROW_ADDR_BITS_DEF = 24;
    localparam int unsigned QUEUE_DEPTH_DEF   = 2;

    // Main page bytes saturate at this value.
    localparam int unsigned MAX_PAGE_BYTES = 8192;

    // Field widths.
    localparam int unsigned PAGE_NUMBER_W = 24;
    localparam int unsigned OFFSET_W      = 13;
    localparam int unsigned COUNT_W       = 14;
    localparam int unsigned CFG_DATA_W    = 8;
    localparam int unsigned SPARE_SHIFT   = 5;

    // Configuration register indexes.
    localparam logic [1:0] CFG_PAGE_SIZE_LOG2 = 2'd0;
    localparam logic [1:0] CFG_BUS_IS_16BIT   = 2'd1;
    localparam logic [1:0] CFG_CHIP_SIZE_LOG2 = 2'd2;

    // Configuration reset values.
    localparam logic [3:0] PAGE_SIZE_LOG2_RST = 4'd11;
    localparam logic       BUS_IS_16BIT_RST   = 1'b0;
    localparam logic [5:0] CHIP_SIZE_LOG2_RST = 6'd27;

    // Classification thresholds.
    localparam logic [3:0] SMALL_PAGE_LOG2  = 4'd9;
    localparam logic [5:0] SMALL_EXTRA_LOG2 = 6'd25;
    localparam logic [5:0] LARGE_EXTRA_LOG2 = 6'd27;

    // Item kinds.
    localparam logic [1:0] KIND_CMD   = 2'd0;
    localparam logic [1:0] KIND_ADDR  = 2'd1;
    localparam logic [1:0] KIND_WAIT  = 2'd2;
    localparam logic [1:0] KIND_BURST = 2'd3;

    // Flash command bytes.
    localparam logic [7:0] OP_READ0     = 8'h00;
    localparam logic [7:0] OP_READ1     = 8'h01;
    localparam logic [7:0] OP_READOOB   = 8'h50;
    localparam logic [7:0] OP_READSTART = 8'h30;

    // Burst targets.
    localparam logic BUF_PAGE  = 1'b0;
    localparam logic BUF_SPARE = 1'b1;

    // Small page half size in words, used as both count and second offset.
    localparam logic [COUNT_W-1:0]  SMALL_HALF_COUNT  = 14'h100;
    localparam logic [OFFSET_W-1:0] SMALL_HALF_OFFSET = 13'h100;
    localparam logic [COUNT_W-1:0]  SMALL_SPARE_BYTES = 14'h10;

    // How a queued page is to be read.
    typedef struct packed {
        logic               small_page;
        logic               bus_16bit;
        logic               extra_row;
        logic [COUNT_W-1:0] main_count;
        logic [COUNT_W-1:0] spare_count;
    } t_mode;

    // One result word.
    typedef struct packed {
        logic [1:0]          kind;
        logic [7:0]          cbyte;
        logic                buf_sel;
        logic [OFFSET_W-1:0] offset;
        logic [COUNT_W-1:0]  count;
        logic                last;
    } t_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CMD,
        S_COL0,
        S_COL1,
        S_ROW0,
        S_ROW1,
        S_ROW2,
        S_START,
        S_WAIT,
        S_BURST_MAIN,
        S_BURST_SPARE
    } t_seq_state;

    typedef enum logic [1:0] {
        PH_READ0,
        PH_READ1,
        PH_OOB
    } t_phase;

endpackage

// ===== rtl/core/nprs_queue.sv =====
// Short request queue between the classifying front and the sequencing back.
module nprs_queue import nprs_pkg::*; #(
    parameter int unsigned ROW_W = ROW_ADDR_BITS_DEF,
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [ROW_W-1:0] i_row,
    input  t_mode            i_mode,
    output logic             o_full,
    input  logic             i_take,
    output logic             o_valid,
    output logic [ROW_W-1:0] o_row,
    output t_mode            o_mode
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [ROW_W-1:0] r_row [DEPTH];
    t_mode            r_mode [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_take;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_row   = r_row[r_rd_ptr];
    assign o_mode  = r_mode[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_take = i_take && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_take) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_take) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_take && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_row[r_wr_ptr]  <= i_row;
            r_mode[r_wr_ptr] <= i_mode;
        end
    end

endmodule

// ===== rtl/core/nprs_front.sv =====
// Front end: configuration registers and classification of page requests.
module nprs_front import nprs_pkg::*; #(
    parameter int unsigned ROW_W = ROW_ADDR_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [1:0]               i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                     i_push,
    input  logic                     i_queue_full,
    input  logic [PAGE_NUMBER_W-1:0] i_page_number,
    output logic                     o_job_push,
    output logic [ROW_W-1:0]         o_job_row,
    output t_mode                    o_job_mode
);

    logic [3:0]  r_page_size_log2;
    logic        r_bus_is_16bit;
    logic [5:0]  r_chip_size_log2;
    logic        small_page;
    logic [15:0] page_bytes_raw;
    logic [15:0] page_bytes;
    logic [15:0] spare_bytes;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_size_log2 <= PAGE_SIZE_LOG2_RST;
            r_bus_is_16bit   <= BUS_IS_16BIT_RST;
            r_chip_size_log2 <= CHIP_SIZE_LOG2_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PAGE_SIZE_LOG2: r_page_size_log2 <= i_cfg_data[3:0];
                CFG_BUS_IS_16BIT:   r_bus_is_16bit   <= i_cfg_data[0];
                CFG_CHIP_SIZE_LOG2: r_chip_size_log2 <= i_cfg_data[5:0];
                default: begin
                end
            endcase
        end
    end

    // Page bytes are a power of two clipped to the largest supported page.
    assign small_page     = (r_page_size_log2 <= SMALL_PAGE_LOG2);
    assign page_bytes_raw = 16'(1) << r_page_size_log2;
    assign page_bytes     = (page_bytes_raw > 16'(MAX_PAGE_BYTES)) ?
                            16'(MAX_PAGE_BYTES) : page_bytes_raw;
    assign spare_bytes    = page_bytes >> SPARE_SHIFT;

    always_comb begin
        o_job_mode.small_page = small_page;
        o_job_mode.bus_16bit  = r_bus_is_16bit;
        if (small_page) begin
            o_job_mode.extra_row   = (r_chip_size_log2 > SMALL_EXTRA_LOG2);
            o_job_mode.main_count  = SMALL_HALF_COUNT;
            o_job_mode.spare_count = SMALL_SPARE_BYTES >> r_bus_is_16bit;
        end else begin
            o_job_mode.extra_row   = (r_chip_size_log2 > LARGE_EXTRA_LOG2);
            o_job_mode.main_count  = COUNT_W'(page_bytes >> r_bus_is_16bit);
            o_job_mode.spare_count = COUNT_W'(spare_bytes >> r_bus_is_16bit);
        end
    end

    assign o_job_push = i_push && !i_queue_full;
    assign o_job_row  = i_page_number[ROW_W-1:0];

endmodule

// ===== rtl/core/nprs_back.sv =====
// Back end: bus cycle sequencer with a registered result stage.
`include "nand_page_read_sequencer_top_defines.svh"

module nprs_back import nprs_pkg::*; #(
    parameter int unsigned ROW_W = ROW_ADDR_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    input  logic [ROW_W-1:0]    i_job_row,
    input  t_mode               i_job_mode,
    output logic                o_job_take,
    input  logic                i_pop,
    output logic                o_empty,
    output logic [1:0]          o_cycle_kind,
    output logic [7:0]          o_cycle_byte,
    output logic                o_buffer_select,
    output logic [OFFSET_W-1:0] o_word_offset,
    output logic [COUNT_W-1:0]  o_word_count,
    output logic                o_last_cycle
);

    t_seq_state       r_state, n_state;
    t_phase           r_phase, n_phase;
    t_mode            r_mode;
    logic [ROW_W-1:0] r_row;
    logic             r_out_valid;
    t_item            r_out;
    t_item            item;
    logic [23:0]      row_ext;
    logic             advance;
    logic             load;

    assign advance    = (r_state != S_IDLE) && (!r_out_valid || i_pop);
    assign load       = i_job_valid &&
                        ((r_state == S_IDLE) || ((r_state == S_BURST_SPARE) && advance));
    assign o_job_take = load;
    assign row_ext    = 24'(r_row);

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        if (load) begin
            n_state = S_CMD;
            n_phase = PH_READ0;
        end else if (advance) begin
            case (r_state)
                S_CMD:  n_state = S_COL0;
                S_COL0: n_state = r_mode.small_page ? S_ROW0 : S_COL1;
                S_COL1: n_state = S_ROW0;
                S_ROW0: n_state = S_ROW1;
                S_ROW1: begin
                    if (r_mode.extra_row) begin
                        n_state = S_ROW2;
                    end else begin
                        n_state = r_mode.small_page ? S_WAIT : S_START;
                    end
                end
                S_ROW2:  n_state = r_mode.small_page ? S_WAIT : S_START;
                S_START: n_state = S_WAIT;
                S_WAIT: begin
                    n_state = (r_mode.small_page && (r_phase == PH_OOB)) ?
                              S_BURST_SPARE : S_BURST_MAIN;
                end
                S_BURST_MAIN: begin
                    if (r_mode.small_page) begin
                        n_state = S_CMD;
                        n_phase = ((r_phase == PH_READ0) && !r_mode.bus_16bit) ?
                                  PH_READ1 : PH_OOB;
                    end else begin
                        n_state = S_BURST_SPARE;
                    end
                end
                S_BURST_SPARE: n_state = S_IDLE;
                default:       n_state = S_IDLE;
            endcase
        end
    end

    always_comb begin
        item = '0;
        case (r_state)
            S_CMD: begin
                item.kind = KIND_CMD;
                case (r_phase)
                    PH_READ1: item.cbyte = OP_READ1;
                    PH_OOB:   item.cbyte = OP_READOOB;
                    default:  item.cbyte = OP_READ0;
                endcase
            end
            S_COL0, S_COL1: item.kind = KIND_ADDR;
            S_ROW0: begin
                item.kind  = KIND_ADDR;
                item.cbyte = row_ext[7:0];
            end
            S_ROW1: begin
                item.kind  = KIND_ADDR;
                item.cbyte = row_ext[15:8];
            end
            S_ROW2: begin
                item.kind  = KIND_ADDR;
                item.cbyte = row_ext[23:16];
            end
            S_START: begin
                item.kind  = KIND_CMD;
                item.cbyte = OP_READSTART;
            end
            S_WAIT: item.kind = KIND_WAIT;
            S_BURST_MAIN: begin
                item.kind    = KIND_BURST;
                item.buf_sel = BUF_PAGE;
                item.offset  = (r_phase == PH_READ1) ? SMALL_HALF_OFFSET : '0;
                item.count   = r_mode.main_count;
            end
            S_BURST_SPARE: begin
                item.kind    = KIND_BURST;
                item.buf_sel = BUF_SPARE;
                item.count   = r_mode.spare_count;
                item.last    = 1'b1;
            end
            default: item = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_READ0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_mode <= i_job_mode;
            r_row  <= i_job_row;
        end
        if (advance) begin
            r_out <= item;
        end
    end

    assign o_empty         = !r_out_valid;
    assign o_cycle_kind    = r_out.kind;
    assign o_cycle_byte    = r_out.cbyte;
    assign o_buffer_select = r_out.buf_sel;
    assign o_word_offset   = r_out.offset;
    assign o_word_count    = r_out.count;
    assign o_last_cycle    = r_out.last;

    `NPRS_ASSERT_NEXT(a_last_after_spare, i_clk, i_rst_n, (r_state == S_BURST_SPARE) && advance, r_out_valid && r_out.last)
    `NPRS_ASSERT_IMPL(a_col1_large_only, i_clk, i_rst_n, r_state == S_COL1, !r_mode.small_page)
    `NPRS_ASSERT_IMPL(a_row2_extra_only, i_clk, i_rst_n, r_state == S_ROW2, r_mode.extra_row)
    `NPRS_ASSERT_IMPL(a_read1_small_8bit, i_clk, i_rst_n, (r_phase == PH_READ1) && (r_state != S_IDLE), r_mode.small_page && !r_mode.bus_16bit)

endmodule

// ===== rtl/core/nand_page_read_sequencer_top.sv =====
// Top level of the NAND page read sequencer.
//
// Each page number pushed in becomes the complete list of NAND bus cycles that
// reads that page: command bytes, address bytes, wait-for-ready markers and
// read burst descriptors (target buffer, first word, word count), one result
// word per cycle while pop is held high, the final word of a page flagged by
// last_cycle. A large page gives 9 or 10 words (READ0, two column bytes, two or
// three row bytes, READSTART, wait, main burst, spare burst of page/32 bytes).
// A small page of 512 bytes gives two or three phases of 6 or 7 words each
// (READ0, READ1 on an 8-bit bus only, READOOB), so 12 to 21 words. The first
// word of a page passes the request queue, the sequencer state register and
// the result register before it appears on the result ports, and the next
// page starts in the cycle after the last word of the previous one. A
// two-entry request queue in front of the sequencer keeps accepting pages while
// a sequence is running; full rises only when that queue holds two pending
// pages. Configuration is sampled when a page is pushed and must be written
// only while the block is idle; the write channel is always ready.
module nand_page_read_sequencer_top import nprs_pkg::*; #(
    parameter int unsigned ROW_ADDR_BITS = ROW_ADDR_BITS_DEF,
    parameter int unsigned QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // Configuration write channel.
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [1:0]               i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    // Page request side.
    input  logic                     push,
    output logic                     full,
    input  logic [PAGE_NUMBER_W-1:0] i_page_number,
    // Result side.
    output logic                     empty,
    input  logic                     pop,
    output logic [1:0]               o_cycle_kind,
    output logic [7:0]               o_cycle_byte,
    output logic                     o_buffer_select,
    output logic [OFFSET_W-1:0]      o_word_offset,
    output logic [COUNT_W-1:0]       o_word_count,
    output logic                     o_last_cycle
);

    // Classified request entering the queue.
    logic                     front_push;
    logic [ROW_ADDR_BITS-1:0] front_row;
    t_mode                    front_mode;

    // Oldest pending request leaving the queue.
    logic                     job_valid;
    logic                     job_take;
    logic [ROW_ADDR_BITS-1:0] job_row;
    t_mode                    job_mode;

    // The front masks the row and works out the burst sizes and whether the
    // extra row byte is needed, using the configuration at push time.
    nprs_front #(
        .ROW_W (ROW_ADDR_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_push        (push),
        .i_queue_full  (full),
        .i_page_number (i_page_number),
        .o_job_push    (front_push),
        .o_job_row     (front_row),
        .o_job_mode    (front_mode)
    );

    // The queue decouples request acceptance from sequence generation.
    nprs_queue #(
        .ROW_W (ROW_ADDR_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_row   (front_row),
        .i_mode  (front_mode),
        .o_full  (full),
        .i_take  (job_take),
        .o_valid (job_valid),
        .o_row   (job_row),
        .o_mode  (job_mode)
    );

    // The back walks the bus cycle list of one page at a time into a
    // registered result stage that stalls only on the result side.
    nprs_back #(
        .ROW_W (ROW_ADDR_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job_valid     (job_valid),
        .i_job_row       (job_row),
        .i_job_mode      (job_mode),
        .o_job_take      (job_take),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_cycle_kind    (o_cycle_kind),
        .o_cycle_byte    (o_cycle_byte),
        .o_buffer_select (o_buffer_select),
        .o_word_offset   (o_word_offset),
        .o_word_count    (o_word_count),
        .o_last_cycle    (o_last_cycle)
    );

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the NAND page read sequencer top level.
`timescale 1ns / 1ps

module testbench import nprs_pkg::*;;

    // Register index that decodes to nothing; writes to it must leave the mode alone.
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    localparam int DIRECTED_ROWS   = 20;
    localparam int RANDOM_BLOCKS   = 8;
    localparam int PAGES_PER_BLOCK = 33;
    localparam int HOLD_OFF_CYCLES = 160;
    localparam int DRAIN_CYCLES    = 30;
    localparam int TIMEOUT_NS      = 2_000_000;

    // One row of the directed plan. Where hand is set, the word count of the
    // sequence and the count of its final burst are typed in from the spec.
    typedef struct packed {
        logic [PAGE_NUMBER_W-1:0] page;
        logic [3:0]               page_log2;
        logic                     bus16;
        logic [5:0]               chip_log2;
        logic                     hand;
        logic [4:0]               n_words;
        logic [COUNT_W-1:0]       tail_count;
    } t_plan_row;

    logic                     i_clk         = 1'b0;
    logic                     i_rst_n       = 1'b0;
    logic                     i_cfg_valid   = 1'b0;
    logic [1:0]               i_cfg_index   = CFG_PAGE_SIZE_LOG2;
    logic [CFG_DATA_W-1:0]    i_cfg_data    = '0;
    logic                     push          = 1'b0;
    logic [PAGE_NUMBER_W-1:0] i_page_number = '0;
    logic                     pop           = 1'b0;
    logic                     o_cfg_ready;
    logic                     full;
    logic                     empty;
    logic [1:0]               o_cycle_kind;
    logic [7:0]               o_cycle_byte;
    logic                     o_buffer_select;
    logic [OFFSET_W-1:0]      o_word_offset;
    logic [COUNT_W-1:0]       o_word_count;
    logic                     o_last_cycle;

    // Mode the predictor works from; follows every accepted register write.
    logic [3:0] cur_page_log2 = PAGE_SIZE_LOG2_RST;
    logic       cur_bus16     = BUS_IS_16BIT_RST;
    logic [5:0] cur_chip_log2 = CHIP_SIZE_LOG2_RST;

    // Bus cycle words still owed by the sequencer, oldest first.
    t_item words_due[$];
    t_item want_word;

    int fail_count     = 0;
    int pages_sent     = 0;
    int words_checked  = 0;
    int cfg_writes     = 0;
    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    // The stimulus bumps hold_asks; the result side notices and holds pop low.
    int hold_asks      = 0;
    int hold_seen      = 0;
    int hold_left      = 0;

    // Directed plan: reset mode first, then both page schemes, both bus widths,
    // both sides of each extra-row threshold, tiny and oversized page sizes,
    // and the extremes of the page number.
    t_plan_row directed_plan [DIRECTED_ROWS] = '{
        '{24'h000000, 4'd11, 1'b0, 6'd27, 1'b1, 5'd9,  14'd64},
        '{24'hFFFFFF, 4'd11, 1'b0, 6'd28, 1'b1, 5'd10, 14'd64},
        '{24'h123456, 4'd11, 1'b1, 6'd28, 1'b1, 5'd10, 14'd32},
        '{24'h000000, 4'd9,  1'b0, 6'd25, 1'b1, 5'd18, 14'd16},
        '{24'hFFFFFF, 4'd9,  1'b0, 6'd26, 1'b1, 5'd21, 14'd16},
        '{24'hA5A5A5, 4'd9,  1'b1, 6'd26, 1'b1, 5'd14, 14'd8},
        '{24'h5A5A5A, 4'd9,  1'b1, 6'd25, 1'b1, 5'd12, 14'd8},
        '{24'h00FF00, 4'd0,  1'b0, 6'd20, 1'b1, 5'd18, 14'd16},
        '{24'hFF00FF, 4'd8,  1'b1, 6'd63, 1'b1, 5'd14, 14'd8},
        '{24'h000001, 4'd10, 1'b0, 6'd0,  1'b1, 5'd9,  14'd32},
        '{24'h800000, 4'd12, 1'b1, 6'd33, 1'b1, 5'd10, 14'd64},
        '{24'h7FFFFF, 4'd13, 1'b0, 6'd27, 1'b1, 5'd9,  14'd256},
        '{24'hFFFFFF, 4'd13, 1'b1, 6'd63, 1'b1, 5'd10, 14'd128},
        '{24'h010203, 4'd14, 1'b0, 6'd28, 1'b1, 5'd10, 14'd256},
        '{24'hFEDCBA, 4'd15, 1'b1, 6'd20, 1'b1, 5'd9,  14'd128},
        '{24'h3C3C3C, 4'd9,  1'b0, 6'd33, 1'b1, 5'd21, 14'd16},
        '{24'hC3E187, 4'd12, 1'b0, 6'd30, 1'b0, 5'd0,  14'd0},
        '{24'h0F0F0F, 4'd9,  1'b1, 6'd27, 1'b0, 5'd0,  14'd0},
        '{24'hF0F0F0, 4'd10, 1'b1, 6'd28, 1'b0, 5'd0,  14'd0},
        '{24'h000100, 4'd11, 1'b0, 6'd27, 1'b0, 5'd0,  14'd0}
    };

    nand_page_read_sequencer_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .push            (push),
        .full            (full),
        .i_page_number   (i_page_number),
        .empty           (empty),
        .pop             (pop),
        .o_cycle_kind    (o_cycle_kind),
        .o_cycle_byte    (o_cycle_byte),
        .o_buffer_select (o_buffer_select),
        .o_word_offset   (o_word_offset),
        .o_word_count    (o_word_count),
        .o_last_cycle    (o_last_cycle)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Command or address word: no burst fields.
    function automatic void add_bus_word(input logic [1:0] kind, input logic [7:0] cbyte);
        words_due.push_back('{kind, cbyte, BUF_PAGE, {OFFSET_W{1'b0}}, {COUNT_W{1'b0}}, 1'b0});
    endfunction

    function automatic void add_burst(input logic tgt, input logic [OFFSET_W-1:0] off,
                                      input logic [COUNT_W-1:0] cnt);
        words_due.push_back('{KIND_BURST, 8'h00, tgt, off, cnt, 1'b0});
    endfunction

    // Row address bytes, low byte first; the third only on chips that need it.
    function automatic void add_row_bytes(input logic [PAGE_NUMBER_W-1:0] row, input logic extra);
        add_bus_word(KIND_ADDR, row[7:0]);
        add_bus_word(KIND_ADDR, row[15:8]);
        if (extra)
            add_bus_word(KIND_ADDR, row[23:16]);
    endfunction

    // Appends the whole bus cycle sequence that reads one page in the current
    // mode, and reports its length and the word count of its final burst.
    function automatic void predict_read_sequence(input logic [PAGE_NUMBER_W-1:0] page,
                                                  output int n_words,
                                                  output logic [COUNT_W-1:0] tail_count);
        int                   first;
        logic [PAGE_NUMBER_W-1:0] row;
        logic                 extra;
        int unsigned          nbytes;
        t_phase               ph;
        logic [7:0]           op;
        logic                 tgt;
        logic [OFFSET_W-1:0]  off;
        logic [COUNT_W-1:0]   cnt;
        t_item                tail;
        first = words_due.size();
        row = PAGE_NUMBER_W'(64'(page) & ((64'd1 << ROW_ADDR_BITS_DEF) - 64'd1));
        if (cur_page_log2 <= SMALL_PAGE_LOG2) begin
            // Small page: one phase per half and one for the spare area, each
            // with its own command, address and wait.
            extra = cur_chip_log2 > SMALL_EXTRA_LOG2;
            for (int s = 0; s < 3; s++) begin
                ph = t_phase'(s);
                case (ph)
                    PH_READ0: begin
                        op  = OP_READ0;
                        tgt = BUF_PAGE;
                        off = '0;
                        cnt = SMALL_HALF_COUNT;
                    end
                    PH_READ1: begin
                        op  = OP_READ1;
                        tgt = BUF_PAGE;
                        off = SMALL_HALF_OFFSET;
                        cnt = SMALL_HALF_COUNT;
                    end
                    default: begin
                        op  = OP_READOOB;
                        tgt = BUF_SPARE;
                        off = '0;
                        cnt = SMALL_SPARE_BYTES >> cur_bus16;
                    end
                endcase
                // A 16-bit bus reads the whole main area in the first phase.
                if (ph == PH_READ1 && cur_bus16)
                    continue;
                add_bus_word(KIND_CMD, op);
                add_bus_word(KIND_ADDR, 8'h00);
                add_row_bytes(row, extra);
                add_bus_word(KIND_WAIT, 8'h00);
                add_burst(tgt, off, cnt);
            end
        end else begin
            extra  = cur_chip_log2 > LARGE_EXTRA_LOG2;
            nbytes = 32'd1 << cur_page_log2;
            if (nbytes > MAX_PAGE_BYTES)
                nbytes = MAX_PAGE_BYTES;
            add_bus_word(KIND_CMD, OP_READ0);
            add_bus_word(KIND_ADDR, 8'h00);
            add_bus_word(KIND_ADDR, 8'h00);
            add_row_bytes(row, extra);
            add_bus_word(KIND_CMD, OP_READSTART);
            add_bus_word(KIND_WAIT, 8'h00);
            add_burst(BUF_PAGE, '0, COUNT_W'(nbytes >> cur_bus16));
            add_burst(BUF_SPARE, '0, COUNT_W'((nbytes >> SPARE_SHIFT) >> cur_bus16));
        end
        tail = words_due.pop_back();
        tail.last = 1'b1;
        words_due.push_back(tail);
        n_words    = words_due.size() - first;
        tail_count = tail.count;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    // Result side: checks every popped word against the oldest one owed, then
    // decides pop for the next edge. A hold-off request forces a long stall.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (words_due.size() == 0) begin
                    $error("word popped with nothing owed: kind %0d, byte 0x%02h",
                           o_cycle_kind, o_cycle_byte);
                    fail_count++;
                end else begin
                    want_word = words_due.pop_front();
                    check_field("cycle_kind", 32'(want_word.kind), 32'(o_cycle_kind));
                    check_field("cycle_byte", 32'(want_word.cbyte), 32'(o_cycle_byte));
                    check_field("buffer_select", 32'(want_word.buf_sel),
                                32'(o_buffer_select));
                    check_field("word_offset", 32'(want_word.offset), 32'(o_word_offset));
                    check_field("word_count", 32'(want_word.count), 32'(o_word_count));
                    check_field("last_cycle", 32'(want_word.last), 32'(o_last_cycle));
                    words_checked++;
                end
            end
            if (hold_seen != hold_asks) begin
                hold_seen = hold_asks;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Offers one page number, after a random gap, and holds it until taken.
    // Push stays high on return so back-to-back pages need no extra edge.
    task automatic send_page(input logic [PAGE_NUMBER_W-1:0] page, output int n_words,
                             output logic [COUNT_W-1:0] tail_count);
        while ($urandom_range(99) < send_gap_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push          <= 1'b1;
        i_page_number <= page;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        // Mode is sampled on acceptance, so predict now.
        predict_read_sequence(page, n_words, tail_count);
        pages_sent++;
    endtask

    // Stops offering and waits until every owed word has been popped.
    task automatic drain_words();
        push <= 1'b0;
        while (words_due.size() != 0)
            @(posedge i_clk);
    endtask

    // Leaves valid high; the caller lowers it after the last write.
    task automatic write_reg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            CFG_PAGE_SIZE_LOG2: cur_page_log2 = data[3:0];
            CFG_BUS_IS_16BIT:   cur_bus16     = data[0];
            CFG_CHIP_SIZE_LOG2: cur_chip_log2 = data[5:0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    // Writes all three mode registers and pokes the unused index. With
    // junk_high the bits above each register's width carry random values,
    // which the block must drop.
    task automatic apply_config(input logic [3:0] page_log2, input logic bus16,
                                input logic [5:0] chip_log2, input logic junk_high);
        logic [CFG_DATA_W-1:0] page_data;
        logic [CFG_DATA_W-1:0] bus_data;
        logic [CFG_DATA_W-1:0] chip_data;
        page_data = {4'h0, page_log2};
        bus_data  = {7'h00, bus16};
        chip_data = {2'b00, chip_log2};
        if (junk_high) begin
            page_data[7:4] = 4'($urandom);
            bus_data[7:1]  = 7'($urandom);
            chip_data[7:6] = 2'($urandom);
        end
        write_reg(CFG_PAGE_SIZE_LOG2, page_data);
        write_reg(CFG_BUS_IS_16BIT, bus_data);
        write_reg(CFG_CHIP_SIZE_LOG2, chip_data);
        write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        t_plan_row                plan_row;
        int                       n_words;
        logic [COUNT_W-1:0]       tail_count;
        logic [PAGE_NUMBER_W-1:0] pg;
        logic [3:0]               rnd_page_log2;
        logic [5:0]               rnd_chip_log2;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, no idling on either side. The mode is only touched
        // once the block has handed over every word it owes.
        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            plan_row = directed_plan[r];
            if (plan_row.page_log2 != cur_page_log2 || plan_row.bus16 != cur_bus16 ||
                plan_row.chip_log2 != cur_chip_log2) begin
                drain_words();
                apply_config(plan_row.page_log2, plan_row.bus16, plan_row.chip_log2, 1'b0);
            end
            send_page(plan_row.page, n_words, tail_count);
            if (plan_row.hand && (n_words != plan_row.n_words ||
                                  tail_count != plan_row.tail_count)) begin
                $error("row %0d: %0d words ending in count %0d, spec says %0d and %0d",
                       r, n_words, tail_count, plan_row.n_words, plan_row.tail_count);
                fail_count++;
            end
        end

        // Random part: a fresh random mode per block, cycling through the
        // idling mixes. The first block also holds the result side off for a
        // long stretch while pages keep coming, so the request queue fills.
        for (int b = 0; b < RANDOM_BLOCKS; b++) begin
            drain_words();
            case ($urandom_range(3))
                0:       rnd_page_log2 = 4'($urandom_range(0, 8));
                1:       rnd_page_log2 = SMALL_PAGE_LOG2;
                default: rnd_page_log2 = 4'($urandom_range(10, 15));
            endcase
            if ($urandom_range(3) == 0)
                rnd_chip_log2 = 6'($urandom_range(0, 63));
            else
                rnd_chip_log2 = 6'($urandom_range(20, 33));
            apply_config(rnd_page_log2, 1'($urandom), rnd_chip_log2, 1'($urandom));
            case (b % 4)
                0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_gap_pct = 58; recv_stall_pct = 0;  end
                2: begin send_gap_pct = 0;  recv_stall_pct = 58; end
                default: begin send_gap_pct = 24; recv_stall_pct = 24; end
            endcase
            if (b == 0)
                hold_asks++;
            for (int k = 0; k < PAGES_PER_BLOCK; k++) begin
                case ($urandom_range(9))
                    0:       pg = '0;
                    1:       pg = '1;
                    2:       pg = PAGE_NUMBER_W'(1) << $urandom_range(PAGE_NUMBER_W - 1);
                    default: pg = PAGE_NUMBER_W'($urandom);
                endcase
                send_page(pg, n_words, tail_count);
            end
        end

        // Let the last sequence finish, then watch a while for stray words.
        drain_words();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("summary: %0d page reads (%0d directed), %0d bus cycle words checked,",
                 pages_sent, DIRECTED_ROWS, words_checked);
        $display("summary: %0d register writes; small and large pages, both bus widths,",
                 cfg_writes);
        $display("summary: idle/stall mixes and one long hold-off");
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #(TIMEOUT_NS);
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/nprs_pkg.sv
rtl/core/nprs_queue.sv
rtl/core/nprs_front.sv
rtl/core/nprs_back.sv
rtl/core/nand_page_read_sequencer_top.sv
verif/testbench.sv
